>>> sv/plsc_pkg.sv
// ----------------------------------------------------------------------------
// plsc_pkg
// Shared constants, job type and magnitude helper for the sensor calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package plsc_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int VALUE_WIDTH = 16;
  localparam int CFG_W       = 4;
  localparam int PIDX_W      = 3;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int NUM_W       = 2 * VALUE_WIDTH + 1;
  localparam int DCNT_W      = $clog2(NUM_W);
  localparam int RES_W       = NUM_W + 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FLAT  = 2'd2;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] base;
    logic [VALUE_WIDTH-1:0] dy_mag;
    logic [VALUE_WIDTH-1:0] ds_mag;
    logic [VALUE_WIDTH-1:0] dx_mag;
    logic                   neg;
    logic [1:0]             status;
  } job_t;

  function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH:0] v);
    logic [VALUE_WIDTH:0] t;
    t = v[VALUE_WIDTH] ? (~v + 1'b1) : v;
    return t[VALUE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/plsc_front.sv
// ----------------------------------------------------------------------------
// plsc_front
// Accepts transactions, keeps the point table, scans it for a convert and
// hands a resolved job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module plsc_front import plsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [VALUE_WIDTH-1:0] sample,
  input  logic [PIDX_W-1:0]      point_index,
  input  logic [VALUE_WIDTH-1:0] point_true,
  input  logic [VALUE_WIDTH-1:0] point_sensed,
  output job_t                   job,
  output logic                   job_push,
  input  logic                   job_space
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state;
  logic [CFG_W-1:0]       point_count;
  logic [CNT_W-1:0]       k;
  logic [CNT_W-1:0]       n;
  logic [CNT_W-1:0]       n_cfg;
  logic                   found;

  logic [VALUE_WIDTH-1:0] tab_true   [MAX_POINTS];
  logic [VALUE_WIDTH-1:0] tab_sensed [MAX_POINTS];

  logic signed [VALUE_WIDTH-1:0] s, x0, t0, px, pt, ppx, ppt, fx0, ft0, fx1, ft1;
  logic signed [VALUE_WIDTH-1:0] cur_x, cur_t;
  logic                          hit;
  logic                          tab_we;

  logic                          direct, unit, last;
  logic signed [VALUE_WIDTH-1:0] y0, y1, xa, xb, xr, dbase;
  logic        [VALUE_WIDTH:0]   dy, ds, dx;
  logic        [1:0]             dstatus;

  assign in_ready = (state == S_IDLE);
  assign n_cfg    = (32'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                    : CNT_W'(point_count);
  assign cur_x    = tab_sensed[k[IDX_W-1:0]];
  assign cur_t    = tab_true[k[IDX_W-1:0]];
  assign hit      = (s >= px) && (s <= cur_x);
  assign tab_we   = in_valid && in_ready && mode && (32'(point_index) < MAX_POINTS);
  assign job_push = (state == S_DONE) && job_space;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      k           <= '0;
      n           <= '0;
      found       <= 1'b0;
    end else begin
      if (cfg_write) begin
        point_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !mode) begin
            n     <= n_cfg;
            k     <= '0;
            found <= 1'b0;
            state <= (n_cfg == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          k <= k + 1'b1;
          if (k != '0 && !found && hit) begin
            found <= 1'b1;
          end
          if (k == n - CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (job_space) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table and scan data
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_true[IDX_W'(point_index)]   <= point_true;
      tab_sensed[IDX_W'(point_index)] <= point_sensed;
    end
    if (state == S_IDLE) begin
      s <= sample;
    end
    if (state == S_SCAN) begin
      if (k == '0) begin
        x0 <= cur_x;
        t0 <= cur_t;
      end
      ppx <= px;
      ppt <= pt;
      px  <= cur_x;
      pt  <= cur_t;
      if (k != '0 && !found && hit) begin
        fx0 <= px;
        ft0 <= pt;
        fx1 <= cur_x;
        ft1 <= cur_t;
      end
    end
  end

  // job resolution
  always_comb begin
    direct  = 1'b0;
    unit    = 1'b0;
    last    = 1'b0;
    dstatus = ST_OK;
    dbase   = '0;
    y0      = ft0;
    y1      = ft1;
    xa      = fx0;
    xb      = fx1;
    if (n == '0) begin
      direct  = 1'b1;
      dstatus = ST_EMPTY;
    end else if (n == CNT_W'(1)) begin
      direct = 1'b1;
      dbase  = t0;
    end else if (s <= x0) begin
      unit = 1'b1;
      y0   = t0;
      xa   = x0;
    end else if (s >= px) begin
      last = 1'b1;
      y0   = ppt;
      y1   = pt;
      xa   = ppx;
      xb   = px;
    end else if (!found) begin
      direct = 1'b1;
    end
    xr = last ? xb : xa;
    dy = {y1[VALUE_WIDTH-1], y1} - {y0[VALUE_WIDTH-1], y0};
    ds = {s[VALUE_WIDTH-1], s} - {xr[VALUE_WIDTH-1], xr};
    dx = {xb[VALUE_WIDTH-1], xb} - {xa[VALUE_WIDTH-1], xa};

    job = '0;
    if (direct) begin
      job.base   = dbase;
      job.status = dstatus;
    end else if (unit) begin
      job.base   = y0;
      job.dy_mag = VALUE_WIDTH'(1);
      job.dx_mag = VALUE_WIDTH'(1);
      job.ds_mag = mag(ds);
      job.neg    = ds[VALUE_WIDTH];
      job.status = ST_OK;
    end else begin
      job.dy_mag = mag(dy);
      job.ds_mag = mag(ds);
      job.dx_mag = mag(dx);
      job.neg    = dy[VALUE_WIDTH] ^ ds[VALUE_WIDTH] ^ dx[VALUE_WIDTH];
      job.status = (dx == '0) ? ST_FLAT : ST_OK;
      job.base   = (last && dx != '0) ? y1 : y0;
    end
  end

endmodule

`default_nettype wire

>>> sv/plsc_queue.sv
// ----------------------------------------------------------------------------
// plsc_queue
// Short job queue between the table scan and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plsc_queue import plsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic space,
  input  logic pop,
  output job_t pop_data,
  output logic pop_valid
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign space     = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/plsc_back.sv
// ----------------------------------------------------------------------------
// plsc_back
// Multiplies, divides with rounding one quotient bit per cycle (both skipped
// for a zero dx), adds the segment base, saturates and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plsc_back import plsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  job_t                   job,
  input  logic                   job_valid,
  output logic                   job_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] corrected,
  output logic [1:0]             status,
  output logic                   saturated
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_ADD  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  localparam logic signed [RES_W-1:0] HI_X =
    {{(RES_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] LO_X =
    {{(RES_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

  logic [2:0]               state;
  logic [DCNT_W-1:0]        cnt;
  job_t                     jb;
  logic [2*VALUE_WIDTH-1:0] prod;
  logic [NUM_W-1:0]         num;
  logic [VALUE_WIDTH-1:0]   rem;

  logic [VALUE_WIDTH:0]     rem_sh;
  logic [VALUE_WIDTH:0]     diff;
  logic                     ge;
  logic signed [RES_W-1:0]  base_x;
  logic signed [RES_W-1:0]  q_x;
  logic signed [RES_W-1:0]  r;
  logic                     out_load;

  assign job_pop  = (state == B_IDLE) && job_valid;
  assign out_load = (state == B_OUT) && (!out_valid || out_ready);

  assign rem_sh = {rem, num[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, jb.dx_mag};
  assign ge     = (rem_sh >= {1'b0, jb.dx_mag});

  assign base_x = {{(RES_W-VALUE_WIDTH){jb.base[VALUE_WIDTH-1]}}, jb.base};
  assign q_x    = {2'b00, num};
  assign r      = jb.neg ? (base_x - q_x) : (base_x + q_x);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            state <= (job.dx_mag == '0) ? B_OUT : B_MUL;
          end
        end
        B_MUL: state <= B_ADD;
        B_ADD: begin
          cnt   <= DCNT_W'(NUM_W - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          jb  <= job;
          num <= '0;
        end
      end
      B_MUL: prod <= jb.dy_mag * jb.ds_mag;
      B_ADD: begin
        num <= {1'b0, prod} + NUM_W'(jb.dx_mag >> 1);
        rem <= '0;
      end
      B_DIV: begin
        rem <= ge ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
        num <= {num[NUM_W-2:0], ge};
      end
      default: ;
    endcase
    if (out_load) begin
      status <= jb.status;
      if (r > HI_X) begin
        corrected <= HI_X[VALUE_WIDTH-1:0];
        saturated <= 1'b1;
      end else if (r < LO_X) begin
        corrected <= LO_X[VALUE_WIDTH-1:0];
        saturated <= 1'b1;
      end else begin
        corrected <= r[VALUE_WIDTH-1:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/piecewise_linear_sensor_calibration.sv
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_calibration
// Piecewise-linear correction of a sensor reading through a table of up to
// MAX_POINTS calibration points, with rounding and saturation.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  cfg      cfg_write              cfg_data (point_count)
//  in       in_valid / in_ready    mode, sample, point_index, point_true,
//                                  point_sensed
//  out      out_valid / out_ready  corrected, status, saturated
//
//  load transaction: no result
//  convert: front scans the table one point per cycle through its single read
//  port; back goes straight to output for a direct value or zero-width segment,
//  else multiplies, adds and runs the serial divider (one quotient bit a cycle)
//  front and back overlap through a two-entry job queue; a stalled output
//  holds the back, then the queue, then the input
//  reset clears control and point_count only; table contents are undefined
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_sensor_calibration import plsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [VALUE_WIDTH-1:0] sample,
  input  logic [PIDX_W-1:0]      point_index,
  input  logic [VALUE_WIDTH-1:0] point_true,
  input  logic [VALUE_WIDTH-1:0] point_sensed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] corrected,
  output logic [1:0]             status,
  output logic                   saturated
);

  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_space;
  logic q_valid;
  logic b_pop;

  plsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .sample       (sample),
    .point_index  (point_index),
    .point_true   (point_true),
    .point_sensed (point_sensed),
    .job          (f_job),
    .job_push     (f_push),
    .job_space    (q_space)
  );

  plsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_job),
    .space     (q_space),
    .pop       (b_pop),
    .pop_data  (q_job),
    .pop_valid (q_valid)
  );

  plsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (q_job),
    .job_valid (q_valid),
    .job_pop   (b_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .corrected (corrected),
    .status    (status),
    .saturated (saturated)
  );

`ifndef SYNTH
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> corrected == '0 && !saturated)
    else $error("empty table result not zero");

  a_flat_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FLAT |-> !saturated)
    else $error("zero-width segment result saturated");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      corrected == {1'b0, {(VALUE_WIDTH-1){1'b1}}} ||
      corrected == {1'b1, {(VALUE_WIDTH-1){1'b0}}})
    else $error("saturated result not at a rail");

  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    f_push |-> q_space)
    else $error("job pushed into full queue");
`endif

endmodule

`default_nettype wire
